/* sv/dms_pkg.sv */
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants for the dual motor speed synchronizer.
// ----------------------------------------------------------------------------
package dms_pkg;

  // field widths
  localparam int SpeedW  = 16;
  localparam int DiffW   = 17;
  localparam int AdjW    = 16;
  localparam int AlphaW  = 17;
  localparam int ThreshW = 16;
  localparam int GainW   = 16;
  localparam int LimitW  = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 17;

  // shared multiplier operand and product widths
  localparam int OpW   = 18;
  localparam int ProdW = 2 * OpW;

  // alpha of one in Q1.16
  localparam logic [AlphaW-1:0] ALPHA_ONE = 17'd65536;

  // register reset values
  localparam logic [AlphaW-1:0]  ALPHA_RST  = ALPHA_ONE;
  localparam logic [ThreshW-1:0] THRESH_RST = 16'd0;
  localparam logic [GainW-1:0]   GAIN_RST   = 16'd256;
  localparam logic [LimitW-1:0]  LIMIT_RST  = 15'd32767;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_GAIN   = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_idx_t;

  // current register values
  typedef struct packed {
    logic [AlphaW-1:0]  alpha;
    logic [ThreshW-1:0] thresh;
    logic [GainW-1:0]   gain;
    logic [LimitW-1:0]  limit;
  } cfg_t;

endpackage

/* sv/dms_in_if.sv */
// ----------------------------------------------------------------------------
// dms_in_if
// Speed sample channel: one left/right pair per beat.
// ----------------------------------------------------------------------------
interface dms_in_if import dms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] left_sample;
  logic signed [SpeedW-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* sv/dms_out_if.sv */
// ----------------------------------------------------------------------------
// dms_out_if
// Result channel: filtered difference and adjustment per beat.
// ----------------------------------------------------------------------------
interface dms_out_if import dms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DiffW-1:0] filtered_difference;
  logic signed [AdjW-1:0]  adjustment;

  modport source (output valid, output filtered_difference, output adjustment, input ready);
  modport sink   (input valid, input filtered_difference, input adjustment, output ready);
endinterface

/* sv/dms_cfg_if.sv */
// ----------------------------------------------------------------------------
// dms_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface dms_cfg_if import dms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/dms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dms_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module dms_cfg_regs import dms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dms_cfg_if.sink   cfg,
  output cfg_t      regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register update
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alpha  <= ALPHA_RST;
      regs.thresh <= THRESH_RST;
      regs.gain   <= GAIN_RST;
      regs.limit  <= LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_ALPHA:  regs.alpha  <= cfg.data[AlphaW-1:0];
        CFG_THRESH: regs.thresh <= cfg.data[ThreshW-1:0];
        CFG_GAIN:   regs.gain   <= cfg.data[GainW-1:0];
        CFG_LIMIT:  regs.limit  <= cfg.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/dms_mult.sv */
// ----------------------------------------------------------------------------
// dms_mult
// Shared signed 18x18 multiplier with registered product.
// ----------------------------------------------------------------------------
module dms_mult import dms_pkg::*; (
  input  logic                    clk,
  input  logic signed [OpW-1:0]   op_a,
  input  logic signed [OpW-1:0]   op_b,
  output logic signed [ProdW-1:0] prod
);

  // product register
  always_ff @(posedge clk) begin
    prod <= ProdW'(op_a) * ProdW'(op_b);
  end

endmodule

/* sv/dms_ctrl.sv */
// ----------------------------------------------------------------------------
// dms_ctrl
// Sequencer and datapath: ema update, deadband test, gain and clamp,
// both products through the shared multiplier.
// ----------------------------------------------------------------------------
module dms_ctrl import dms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    regs,
  dms_in_if.sink                  samples,
  dms_out_if.source               results,
  output logic signed [OpW-1:0]   op_a,
  output logic signed [OpW-1:0]   op_b,
  input  logic signed [ProdW-1:0] prod
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_EMA,
    S_MUL2,
    S_ADJ
  } state_t;

  localparam int AdjFullW = ProdW - 8;

  state_t                  state;
  logic signed [DiffW-1:0] smoothed;
  logic                    in_band;

  logic signed [OpW-1:0]      diff_next;
  logic [AlphaW-1:0]          alpha_sat;
  logic signed [DiffW-1:0]    f_next;
  logic [ThreshW-1:0]         mag_next;
  logic signed [AdjFullW-1:0] adj_full;
  logic signed [AdjFullW-1:0] lim_pos;
  logic signed [AdjW-1:0]     adj_next;
  logic                       out_free;

  assign samples.ready = (state == S_IDLE);
  assign out_free      = !results.valid || results.ready;

  // raw difference minus old state, the ema step input
  assign diff_next = OpW'(samples.left_sample) - OpW'(samples.right_sample) - OpW'(smoothed);

  // alpha above one behaves as one
  assign alpha_sat = regs.alpha[AlphaW-1] ? ALPHA_ONE : regs.alpha;

  // new state: old plus floor of alpha times step over 2^16
  assign f_next = smoothed + DiffW'(prod >>> 16);

  // magnitude of the new state fits 16 bits
  assign mag_next = f_next[DiffW-1] ? ThreshW'(-f_next) : ThreshW'(f_next);

  // gain product floor over 2^8, then clamp
  assign adj_full = AdjFullW'(prod >>> 8);
  assign lim_pos  = AdjFullW'($signed({1'b0, regs.limit}));

  always_comb begin
    if (!in_band) begin
      adj_next = '0;
    end else if (adj_full > lim_pos) begin
      adj_next = AdjW'(lim_pos);
    end else if (adj_full < -lim_pos) begin
      adj_next = AdjW'(-lim_pos);
    end else begin
      adj_next = AdjW'(adj_full);
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      smoothed      <= '0;
      results.valid <= 1'b0;
    end else begin
      // output valid: set on load, cleared once taken
      if (state == S_ADJ && out_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            op_a  <= diff_next;
            op_b  <= OpW'($signed({1'b0, alpha_sat}));
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          state <= S_EMA;
        end
        S_EMA: begin
          smoothed <= f_next;
          in_band  <= (mag_next >= regs.thresh);
          op_a     <= OpW'(f_next);
          op_b     <= OpW'($signed({1'b0, regs.gain}));
          state    <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_ADJ;
        end
        S_ADJ: begin
          if (out_free) begin
            results.filtered_difference <= smoothed;
            results.adjustment          <= adj_next;
            state                       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/dual_motor_speed_sync.sv */
// ----------------------------------------------------------------------------
// dual_motor_speed_sync
// Left/right motor speed synchronizer: ema-filtered difference with deadband
// and clamped proportional correction.
// ----------------------------------------------------------------------------
// Each accepted sample beat produces exactly one result beat. The accept
// cycle forms the raw difference, then a small sequencer runs two passes
// through one shared 18x18 multiplier (alpha times the ema step, then gain
// times the filtered difference), each pass a product step plus an add,
// shift and compare step. The next sample is taken the cycle after the
// result is loaded into the output register, so only one sample is in
// flight at a time; a result still waiting in the output register holds
// the sequencer in its last step. Register writes are taken at any time
// and should only happen while the block is idle.
module dual_motor_speed_sync import dms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dms_in_if.sink     samples,
  dms_out_if.source  results,
  dms_cfg_if.sink    cfg
);

  cfg_t                    regs;
  logic signed [OpW-1:0]   op_a;
  logic signed [OpW-1:0]   op_b;
  logic signed [ProdW-1:0] prod;

  // configuration registers
  dms_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // shared multiplier
  dms_mult u_mult (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // sequencer and datapath
  dms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .samples (samples),
    .results (results),
    .op_a    (op_a),
    .op_b    (op_b),
    .prod    (prod)
  );

endmodule
